/* hw/rtl/e2q_pkg.sv */
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared types, constants and tables of the Euler-angle to quaternion unit.
// ----------------------------------------------------------------------------
package e2q_pkg;

   // Field widths of the transaction payloads and the default CORDIC cell count
   localparam int ANGLE_BITS      = 16;
   localparam int QUAT_BITS       = 16;
   localparam int TRIG_STAGES_DEF = 16;

   // Angle units: 1/256 degree of half angle
   localparam int TURN_UNITS         = 92160;
   localparam int HALF_TURN_UNITS    = 46080;
   localparam int QUARTER_TURN_UNITS = 23040;

   // Degrees-to-radians factor (Q46) and CORDIC gain compensation (Q30)
   localparam logic [32:0] RAD_PER_UNIT_Q46 = 33'd4797524517;
   localparam int          CORDIC_GAIN_Q30  = 652032874;
   // Largest radian magnitude after folding (90 degrees, Q30)
   localparam int          RAD_LIMIT_Q30    = 1686629713;

   // Datapath widths: CORDIC lanes and multiplier operands
   localparam int CW = 34;
   localparam int TW = 32;

   // Turn reduction: a non-negative offset, then one compare/subtract per step
   localparam int    RED_WIDTH  = ((ANGLE_BITS > 17) ? ANGLE_BITS : 17) + 1;
   localparam int    RED_STEPS  = RED_WIDTH - 16;
   localparam longint RED_OFFSET = longint'(TURN_UNITS) *
      (((longint'(1) << (ANGLE_BITS - 1)) + longint'(TURN_UNITS) - 1) /
       longint'(TURN_UNITS));

   // Pipeline depths outside the CORDIC chain
   localparam int PREP_LATENCY = RED_STEPS + 5;
   localparam int COMB_LATENCY = 6;

   // atan(2^-i) in Q30 radians
   localparam logic [31:0] ATAN_Q30 [32] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
      32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic signed [ANGLE_BITS-1:0] roll_angle;
      logic signed [ANGLE_BITS-1:0] pitch_angle;
      logic signed [ANGLE_BITS-1:0] yaw_angle;
   } req_type;

   typedef struct packed {
      logic signed [QUAT_BITS-1:0] quat_x;
      logic signed [QUAT_BITS-1:0] quat_y;
      logic signed [QUAT_BITS-1:0] quat_z;
      logic signed [QUAT_BITS-1:0] quat_w;
   } rsp_type;

   // One CORDIC lane as it moves from cell to cell
   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
      logic                 neg;
   } trig_lane_type;

endpackage

/* hw/rtl/euler_to_quaternion_unit.sv */
// ----------------------------------------------------------------------------
// euler_to_quaternion_unit
// Roll, pitch and yaw (degrees, 1/128 LSB) to a ZYX unit quaternion (Q1.15).
// ----------------------------------------------------------------------------
// Usage:
//   A transaction enters when start is high and busy is low; req_data holds
//   the three angles. busy stays low: the datapath is a fixed pipeline and
//   takes a new transaction in every cycle.
//   Each result appears on rsp_data for exactly one cycle with rsp_strobe
//   high, in the order the transactions entered. The receiver cannot stall;
//   it must take each result in the cycle it is shown.
//   A result passes through the prep pipeline (turn reduction, fold, radian
//   multiply), one cell per CORDIC iteration and the six-stage product/round
//   section. Throughput is one transaction per cycle.
//   Synchronous reset clears the valid pipeline; transactions in flight are
//   dropped and no strobe is shown until new ones come through.
// ----------------------------------------------------------------------------
module euler_to_quaternion_unit
   import e2q_pkg::*;
#(
   parameter int TRIG_STAGES = TRIG_STAGES_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int LATENCY = PREP_LATENCY + TRIG_STAGES + COMB_LATENCY;

   logic                          accept;
   logic [LATENCY-1:0]            vld_ff;
   logic [LATENCY-1:0]            vld_in;
   logic signed [ANGLE_BITS-1:0]  angle [3];
   trig_lane_type                 chain [3][TRIG_STAGES+1];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Valid flags track transactions through the pipeline
   assign vld_in = {vld_ff[LATENCY-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign angle[0] = req_data.roll_angle;
   assign angle[1] = req_data.pitch_angle;
   assign angle[2] = req_data.yaw_angle;

   // Per-angle prep and CORDIC row
   for (genvar a = 0; a < 3; a++) begin : g_axis
      e2q_prep u_prep (
         .clock    (clock),
         .angle_in (angle[a]),
         .lane_out (chain[a][0])
      );
      for (genvar s = 0; s < TRIG_STAGES; s++) begin : g_cell
         e2q_trig_cell #(
            .STAGE (s)
         ) u_cell (
            .clock    (clock),
            .lane_in  (chain[a][s]),
            .lane_out (chain[a][s+1])
         );
      end
   end

   e2q_combine u_combine (
      .clock      (clock),
      .roll_lane  (chain[0][TRIG_STAGES]),
      .pitch_lane (chain[1][TRIG_STAGES]),
      .yaw_lane   (chain[2][TRIG_STAGES]),
      .rsp_out    (rsp_data)
   );

   assign rsp_strobe = vld_ff[LATENCY-1];

   // Every result strobe traces back to an accepted transaction
   a_strobe_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LATENCY))
      else $error("result strobe without a matching transaction");

   // Folded angles entering the CORDIC row stay within +-90 degrees
   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[PREP_LATENCY-1] |->
         (chain[0][0].z <= CW'(RAD_LIMIT_Q30)) && (chain[0][0].z >= -CW'(RAD_LIMIT_Q30)) &&
         (chain[1][0].z <= CW'(RAD_LIMIT_Q30)) && (chain[1][0].z >= -CW'(RAD_LIMIT_Q30)) &&
         (chain[2][0].z <= CW'(RAD_LIMIT_Q30)) && (chain[2][0].z >= -CW'(RAD_LIMIT_Q30)))
      else $error("folded angle outside quarter turn");

   // Reset flushes the pipeline
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

endmodule

/* hw/rtl/e2q_prep.sv */
// ----------------------------------------------------------------------------
// e2q_prep
// Half-angle reduction to one turn, fold into +-90 degrees, conversion to
// Q30 radians; loads the first CORDIC lane.
// ----------------------------------------------------------------------------
module e2q_prep
   import e2q_pkg::*;
(
   input  logic                         clock,
   input  logic signed [ANGLE_BITS-1:0] angle_in,
   output trig_lane_type                lane_out
);

   localparam logic [RED_WIDTH-1:0] OFFSET_U = RED_WIDTH'(RED_OFFSET);

   logic [RED_WIDTH-1:0]     red_ff [RED_STEPS+1];
   logic signed [17:0]       wrap_ff;
   logic [14:0]              mag_ff;
   logic                     msgn_ff;
   logic                     mneg_ff;
   logic [47:0]              prod_ff;
   logic                     psgn_ff;
   logic                     pneg_ff;
   trig_lane_type            lane_ff;

   logic [16:0]              red_res;
   logic signed [17:0]       wrap_in;
   logic signed [17:0]       fold;
   logic                     fold_neg;
   logic [14:0]              mag_in;
   logic [47:0]              prod_in;
   logic [47:0]              prod_rnd;
   logic signed [CW-1:0]     zmag;
   trig_lane_type            lane_in;

   // Multiple of a turn removed by reduction stage j
   function automatic logic [RED_WIDTH-1:0] turn_multiple(input int j);
      return RED_WIDTH'(longint'(TURN_UNITS) << (RED_STEPS - 1 - j));
   endfunction

   // Offset to a non-negative value that is a whole number of turns away,
   // then restoring reduction: one multiple of a turn per stage
   always_ff @(posedge clock) begin
      red_ff[0] <= RED_WIDTH'(angle_in) + OFFSET_U;
      for (int j = 0; j < RED_STEPS; j++) begin
         if (red_ff[j] >= turn_multiple(j)) begin
            red_ff[j+1] <= red_ff[j] - turn_multiple(j);
         end else begin
            red_ff[j+1] <= red_ff[j];
         end
      end
   end

   // Wrap into (-half turn, +half turn]
   always_comb begin
      red_res = red_ff[RED_STEPS][16:0];
      if (red_res > 17'(HALF_TURN_UNITS)) begin
         wrap_in = $signed({1'b0, red_res}) - 18'sd92160;
      end else begin
         wrap_in = $signed({1'b0, red_res});
      end
   end

   // Fold into +-90 degrees; sine and cosine flip sign when folded
   always_comb begin
      fold     = wrap_ff;
      fold_neg = 1'b0;
      if (wrap_ff > 18'sd23040) begin
         fold     = wrap_ff - 18'sd46080;
         fold_neg = 1'b1;
      end else if (wrap_ff < -18'sd23040) begin
         fold     = wrap_ff + 18'sd46080;
         fold_neg = 1'b1;
      end
      if (fold[17]) begin
         mag_in = 15'(-fold);
      end else begin
         mag_in = 15'(fold);
      end
   end

   assign prod_in  = 48'(mag_ff) * 48'(RAD_PER_UNIT_Q46);
   assign prod_rnd = prod_ff + 48'd32768;
   assign zmag     = $signed({2'b00, prod_rnd[47:16]});

   // First lane: gain-compensated unit vector and the angle in radians
   always_comb begin
      lane_in.x   = CW'(CORDIC_GAIN_Q30);
      lane_in.y   = '0;
      lane_in.z   = psgn_ff ? -zmag : zmag;
      lane_in.neg = pneg_ff;
   end

   always_ff @(posedge clock) begin
      wrap_ff <= wrap_in;
      mag_ff  <= mag_in;
      msgn_ff <= fold[17];
      mneg_ff <= fold_neg;
      prod_ff <= prod_in;
      psgn_ff <= msgn_ff;
      pneg_ff <= mneg_ff;
      lane_ff <= lane_in;
   end

   assign lane_out = lane_ff;

endmodule

/* hw/rtl/e2q_trig_cell.sv */
// ----------------------------------------------------------------------------
// e2q_trig_cell
// One rotation-mode CORDIC iteration, registered; cells chain into a row.
// ----------------------------------------------------------------------------
module e2q_trig_cell
   import e2q_pkg::*;
#(
   parameter int STAGE = 0
)
(
   input  logic          clock,
   input  trig_lane_type lane_in,
   output trig_lane_type lane_out
);

   localparam logic signed [CW-1:0] ATAN_I = $signed(CW'(ATAN_Q30[STAGE]));

   trig_lane_type       lane_ff;
   trig_lane_type       lane_nx;
   logic signed [CW-1:0] dx;
   logic signed [CW-1:0] dy;

   // Rotate toward z = 0
   always_comb begin
      dx          = lane_in.y >>> STAGE;
      dy          = lane_in.x >>> STAGE;
      lane_nx.neg = lane_in.neg;
      if (!lane_in.z[CW-1]) begin
         lane_nx.x = lane_in.x - dx;
         lane_nx.y = lane_in.y + dy;
         lane_nx.z = lane_in.z - ATAN_I;
      end else begin
         lane_nx.x = lane_in.x + dx;
         lane_nx.y = lane_in.y - dy;
         lane_nx.z = lane_in.z + ATAN_I;
      end
   end

   always_ff @(posedge clock) begin
      lane_ff <= lane_nx;
   end

   assign lane_out = lane_ff;

endmodule

/* hw/rtl/e2q_combine.sv */
// ----------------------------------------------------------------------------
// e2q_combine
// Products of the half-angle sines and cosines, sums, and rounding and
// saturation to the quaternion output format.
// ----------------------------------------------------------------------------
module e2q_combine
   import e2q_pkg::*;
(
   input  logic          clock,
   input  trig_lane_type roll_lane,
   input  trig_lane_type pitch_lane,
   input  trig_lane_type yaw_lane,
   output rsp_type       rsp_out
);

   localparam int VW  = CW + 2;
   localparam int QSH = 31 - QUAT_BITS;
   localparam logic signed [63:0]   RND30 = 64'sd536870912;
   localparam logic signed [VW-1:0] QRND  = VW'(1) << ((QSH > 0) ? QSH - 1 : 0);
   localparam logic signed [VW-1:0] QHI   = (VW'(1) <<< (QUAT_BITS - 1)) - VW'(1);
   localparam logic signed [VW-1:0] QLO   = -(VW'(1) <<< (QUAT_BITS - 1));

   // sr, cr, sp, cp, sy, cy after the fold sign
   logic signed [TW-1:0] trig_ff [6];
   logic signed [63:0]   p1_ff [4];
   logic signed [TW-1:0] cy2_ff, sy2_ff, cy3_ff, sy3_ff;
   logic signed [TW-1:0] r1_ff [4];
   logic signed [63:0]   p2_ff [8];
   logic signed [CW-1:0] sum_ff [4];
   rsp_type              rsp_ff;

   logic signed [63:0]   r1_wide [4];
   logic signed [63:0]   r2_wide [8];
   logic signed [CW-1:0] r2 [8];
   logic signed [VW-1:0] vq [4];
   logic signed [QUAT_BITS-1:0] sat [4];

   // Stage 1: apply the fold sign
   always_ff @(posedge clock) begin
      trig_ff[0] <= TW'(roll_lane.neg  ? -roll_lane.y  : roll_lane.y);
      trig_ff[1] <= TW'(roll_lane.neg  ? -roll_lane.x  : roll_lane.x);
      trig_ff[2] <= TW'(pitch_lane.neg ? -pitch_lane.y : pitch_lane.y);
      trig_ff[3] <= TW'(pitch_lane.neg ? -pitch_lane.x : pitch_lane.x);
      trig_ff[4] <= TW'(yaw_lane.neg   ? -yaw_lane.y   : yaw_lane.y);
      trig_ff[5] <= TW'(yaw_lane.neg   ? -yaw_lane.x   : yaw_lane.x);
   end

   // Stage 2: roll by pitch products; cc, ss, cs, sc
   always_ff @(posedge clock) begin
      p1_ff[0] <= 64'(trig_ff[1]) * 64'(trig_ff[3]);
      p1_ff[1] <= 64'(trig_ff[0]) * 64'(trig_ff[2]);
      p1_ff[2] <= 64'(trig_ff[1]) * 64'(trig_ff[2]);
      p1_ff[3] <= 64'(trig_ff[0]) * 64'(trig_ff[3]);
      sy2_ff   <= trig_ff[4];
      cy2_ff   <= trig_ff[5];
   end

   // Stage 3: round back to Q30
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         r1_wide[k] = (p1_ff[k] + RND30) >>> 30;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         r1_ff[k] <= r1_wide[k][TW-1:0];
      end
      sy3_ff <= sy2_ff;
      cy3_ff <= cy2_ff;
   end

   // Stage 4: products with yaw, paired per component
   always_ff @(posedge clock) begin
      p2_ff[0] <= 64'(r1_ff[3]) * 64'(cy3_ff);
      p2_ff[1] <= 64'(r1_ff[2]) * 64'(sy3_ff);
      p2_ff[2] <= 64'(r1_ff[2]) * 64'(cy3_ff);
      p2_ff[3] <= 64'(r1_ff[3]) * 64'(sy3_ff);
      p2_ff[4] <= 64'(r1_ff[0]) * 64'(sy3_ff);
      p2_ff[5] <= 64'(r1_ff[1]) * 64'(cy3_ff);
      p2_ff[6] <= 64'(r1_ff[0]) * 64'(cy3_ff);
      p2_ff[7] <= 64'(r1_ff[1]) * 64'(sy3_ff);
   end

   // Stage 5: round and combine
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         r2_wide[k] = (p2_ff[k] + RND30) >>> 30;
         r2[k]      = r2_wide[k][CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      sum_ff[0] <= r2[0] - r2[1];
      sum_ff[1] <= r2[2] + r2[3];
      sum_ff[2] <= r2[4] - r2[5];
      sum_ff[3] <= r2[6] + r2[7];
   end

   // Stage 6: scale to the output format and saturate
   for (genvar k = 0; k < 4; k++) begin : g_out
      if (QSH > 0) begin : g_rnd
         assign vq[k] = (VW'(sum_ff[k]) + QRND) >>> QSH;
      end else if (QSH == 0) begin : g_same
         assign vq[k] = VW'(sum_ff[k]);
      end else begin : g_up
         assign vq[k] = VW'(sum_ff[k]) <<< (-QSH);
      end
      always_comb begin
         if (vq[k] > QHI) begin
            sat[k] = QHI[QUAT_BITS-1:0];
         end else if (vq[k] < QLO) begin
            sat[k] = QLO[QUAT_BITS-1:0];
         end else begin
            sat[k] = vq[k][QUAT_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff.quat_x <= sat[0];
      rsp_ff.quat_y <= sat[1];
      rsp_ff.quat_z <= sat[2];
      rsp_ff.quat_w <= sat[3];
   end

   assign rsp_out = rsp_ff;

endmodule
